/* rtl/connection_timeout_timer_queue_core_defines.svh */
// ============================================================================
// connection_timeout_timer_queue_core_defines
// Assertion macros used by the timer queue core.
// ============================================================================
`ifndef CONNECTION_TIMEOUT_TIMER_QUEUE_CORE_DEFINES_SVH
`define CONNECTION_TIMEOUT_TIMER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, masked while reset is active
`define CTQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is active
`define CTQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ctq_pkg.sv */
// ============================================================================
// ctq_pkg
// Types and constants of the connection timeout timer queue.
// ============================================================================
package ctq_pkg;

    // results one tick may report
    localparam int MAX_RESULTS = 16;
    localparam int POP_W       = $clog2(MAX_RESULTS + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIME       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_ON_TIMEOUT = 2'd1;
    localparam logic [15:0]          WAIT_TIME_RESET     = 16'd20;

    // request actions
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_DELETED = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    // one word of the entry memory
    typedef struct packed {
        logic        valid;
        logic        due;
        logic [31:0] deadline;
        logic [15:0] conn;
        logic [31:0] sequence_num;
        logic [31:0] order;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/ctq_if.sv */
// ============================================================================
// ctq_if
// Valid/ready channels of the timer queue: requests, results, configuration.
// ============================================================================

// request channel
interface ctq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] conn_id;
    logic [31:0] sequence_req;
    logic [31:0] now;

    modport source (output valid, output action, output conn_id, output sequence_req,
                    output now, input ready);
    modport sink (input valid, input action, input conn_id, input sequence_req,
                  input now, output ready);
endinterface

// result channel
interface ctq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] conn_id_out;
    logic [31:0] sequence_out;
    logic [4:0]  removed_count;
    logic [4:0]  entries_in_use;
    logic [31:0] earliest_expiry;
    logic        earliest_valid;
    logic        last;

    modport source (output valid, output kind, output conn_id_out, output sequence_out,
                    output removed_count, output entries_in_use, output earliest_expiry,
                    output earliest_valid, output last, input ready);
    modport sink (input valid, input kind, input conn_id_out, input sequence_out,
                  input removed_count, input entries_in_use, input earliest_expiry,
                  input earliest_valid, input last, output ready);
endinterface

// configuration write channel
interface ctq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ctq_pkg::CFG_IDX_W-1:0]  index;
    logic [ctq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/connection_timeout_timer_queue_core.sv */
// ============================================================================
// connection_timeout_timer_queue_core
// Bounded table of connection deadlines kept in one entry memory. Every add,
// delete and tick request is served by passes over the whole memory that find
// a free slot, the earliest deadline and the next due entry in expiry order.
// ============================================================================
//
//  channel  role  handshake    payload
//  req      in    valid/ready  action, conn_id, sequence_req, now
//  rsp      out   valid/ready  kind, conn_id_out, sequence_out, removed_count,
//                              entries_in_use, earliest_expiry, earliest_valid, last
//  cfg      in    valid/ready  index, data (ready is always high)
//
//  one pass reads the entry memory one word a cycle
//  add and delete: one pass from accept to result
//  tick popping n entries: n + 1 passes
//  after reset every entry of the memory is swept clear with req.ready low
//  results leave through an output register; a stalled rsp holds the sequencer
//  at its decision step, and req is taken once the sequencer is idle
//
`include "connection_timeout_timer_queue_core_defines.svh"

module connection_timeout_timer_queue_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ctq_req_if.sink      req,
    ctq_rsp_if.source    rsp,
    ctq_cfg_if.sink      cfg
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [ctq_pkg::POP_W-1:0] POP_LIMIT = ctq_pkg::POP_W'(ctq_pkg::MAX_RESULTS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    // saturating deadline
    function automatic logic [31:0] deadline_from(input logic [31:0] t, input logic [15:0] w);
        logic [32:0] sum;
        sum = {1'b0, t} + {17'd0, w};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    state_t state_reg;

    // configuration
    logic [15:0] wait_reg;
    logic        kick_reg;

    // latched request
    ctq_pkg::action_t op_reg;
    logic [15:0]      conn_reg;
    logic [31:0]      seq_reg;
    logic [31:0]      now_reg;
    logic [31:0]      dl_reg;

    // table bookkeeping
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      stamp_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // scan pipeline control
    logic             snap_reg;
    logic             issue_on_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             a_vld_reg;
    logic             a_last_reg;
    logic [IDX_W-1:0] a_idx_reg;
    logic             b_vld_reg;
    logic             b_last_reg;

    // scan stage b payload
    ctq_pkg::entry_t  b_entry_reg;
    logic             b_live_reg;
    logic             b_elig_reg;
    logic             b_free_reg;
    logic             b_hit_reg;
    logic [31:0]      b_age_reg;
    logic [IDX_W-1:0] b_idx_reg;

    // pass accumulators
    logic             min_any_reg;
    logic [31:0]      min_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [CNT_W-1:0] removed_reg;
    logic             pick_found_reg;
    logic [IDX_W-1:0] pick_idx_reg;
    logic [31:0]      pick_dl_reg;
    logic [31:0]      pick_age_reg;
    logic [15:0]      pick_conn_reg;
    logic [31:0]      pick_seq_reg;

    // tick progress
    logic [ctq_pkg::POP_W-1:0] pops_reg;
    logic                      pend_vld_reg;
    logic [15:0]               pend_conn_reg;
    logic [31:0]               pend_seq_reg;
    logic [CNT_W-1:0]          pend_count_reg;

    // result register
    logic        out_vld_reg;
    logic [2:0]  out_kind_reg;
    logic [15:0] out_conn_reg;
    logic [31:0] out_seq_reg;
    logic [4:0]  out_removed_reg;
    logic [4:0]  out_used_reg;
    logic [31:0] out_earliest_reg;
    logic        out_evalid_reg;
    logic        out_last_reg;

    // memory ports
    logic                        ram_wr_en;
    logic [IDX_W-1:0]            ram_wr_addr;
    logic [ctq_pkg::ENTRY_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [ctq_pkg::ENTRY_W-1:0] ram_rd_data;
    ctq_pkg::entry_t             wr_entry;
    ctq_pkg::entry_t             a_entry;

    // combinational helpers
    logic             req_acc;
    logic             out_free;
    logic             out_load;
    logic             pass_start;
    logic             is_del;
    logic             is_tick;
    logic             a_hit;
    logic             a_live;
    logic             a_due_now;
    logic             a_elig;
    logic [31:0]      a_age;
    logic             tick_pop;
    logic             tick_emit;
    logic [31:0]      pass_min;
    logic [31:0]      add_earliest;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_del;
    logic [CNT_W-1:0] count_pop;
    logic             b_better;

    // entry memory
    ctq_ram #(
        .WIDTH (ctq_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    // handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign out_free  = !out_vld_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // result channel
    assign rsp.valid           = out_vld_reg;
    assign rsp.kind            = out_kind_reg;
    assign rsp.conn_id_out     = out_conn_reg;
    assign rsp.sequence_out    = out_seq_reg;
    assign rsp.removed_count   = out_removed_reg;
    assign rsp.entries_in_use  = out_used_reg;
    assign rsp.earliest_expiry = out_earliest_reg;
    assign rsp.earliest_valid  = out_evalid_reg;
    assign rsp.last            = out_last_reg;

    // stage a: word just read from memory
    assign a_entry   = ctq_pkg::entry_t'(ram_rd_data);
    assign is_del    = (op_reg == ctq_pkg::ACT_DELETE);
    assign is_tick   = (op_reg == ctq_pkg::ACT_TICK);
    assign a_hit     = is_del && a_entry.valid && (a_entry.conn == conn_reg);
    assign a_live    = a_entry.valid && !a_hit;
    assign a_due_now = a_entry.valid && (a_entry.deadline <= now_reg);
    assign a_elig    = is_tick && (snap_reg ? a_due_now : (a_entry.valid && a_entry.due));
    assign a_age     = stamp_reg - a_entry.order;
    assign ram_rd_en = (state_reg == S_SCAN) && issue_on_reg;

    // stage b: expiry order, older insertion first on equal deadlines
    assign b_better = !pick_found_reg
                      || (b_entry_reg.deadline < pick_dl_reg)
                      || ((b_entry_reg.deadline == pick_dl_reg) && (b_age_reg > pick_age_reg));

    // decision terms
    assign tick_pop     = pick_found_reg && (pops_reg != POP_LIMIT);
    assign tick_emit    = pend_vld_reg || !pick_found_reg;
    assign pass_min     = min_any_reg ? min_reg : 32'd0;
    assign add_earliest = (min_any_reg && (min_reg < dl_reg)) ? min_reg : dl_reg;
    assign count_inc    = count_reg + 1'b1;
    assign count_del    = count_reg - removed_reg;
    assign count_pop    = kick_reg ? (count_reg - 1'b1) : count_reg;

    // result register loads a new request result this cycle
    assign out_load = (state_reg == S_DECIDE) && out_free
                      && ((op_reg == ctq_pkg::ACT_ADD) || is_del || (is_tick && tick_emit));

    assign pass_start = (req_acc && (req.action inside {ctq_pkg::ACT_ADD, ctq_pkg::ACT_DELETE,
                                                        ctq_pkg::ACT_TICK}))
                        || ((state_reg == S_DECIDE) && out_free && is_tick && tick_pop);

    // memory write select
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = a_idx_reg;
        wr_entry    = a_entry;
        if (state_reg == S_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_idx_reg;
            wr_entry    = '0;
        end
        else if ((state_reg == S_SCAN) && a_vld_reg && (a_hit || (is_tick && snap_reg)))
        begin
            // delete clears matches, first tick pass marks the due set
            ram_wr_en      = 1'b1;
            wr_entry.valid = a_live;
            if (snap_reg)
            begin
                wr_entry.due = a_due_now;
            end
        end
        else if ((state_reg == S_DECIDE) && out_free)
        begin
            if ((op_reg == ctq_pkg::ACT_ADD) && free_found_reg)
            begin
                ram_wr_en             = 1'b1;
                ram_wr_addr           = free_idx_reg;
                wr_entry.valid        = 1'b1;
                wr_entry.due          = 1'b0;
                wr_entry.deadline     = dl_reg;
                wr_entry.conn         = conn_reg;
                wr_entry.sequence_num = seq_reg;
                wr_entry.order        = stamp_reg;
            end
            else if (is_tick && tick_pop)
            begin
                // pop: drop or re-arm the picked entry
                ram_wr_en             = 1'b1;
                ram_wr_addr           = pick_idx_reg;
                wr_entry.valid        = !kick_reg;
                wr_entry.due          = 1'b0;
                wr_entry.deadline     = dl_reg;
                wr_entry.conn         = pick_conn_reg;
                wr_entry.sequence_num = pick_seq_reg;
                wr_entry.order        = stamp_reg;
            end
        end
    end

    assign ram_wr_data = wr_entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= ctq_pkg::WAIT_TIME_RESET;
            kick_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ctq_pkg::CFG_WAIT_TIME:       wait_reg <= cfg.data[15:0];
                ctq_pkg::CFG_KICK_ON_TIMEOUT: kick_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            op_reg   <= ctq_pkg::action_t'(req.action);
            conn_reg <= req.conn_id;
            seq_reg  <= req.sequence_req;
            now_reg  <= req.now;
            dl_reg   <= deadline_from(req.now, wait_reg);
        end
    end

    // scan stage b payload
    always_ff @(posedge clk)
    begin
        b_entry_reg <= a_entry;
        b_live_reg  <= a_live;
        b_elig_reg  <= a_elig;
        b_free_reg  <= !a_entry.valid;
        b_hit_reg   <= a_hit;
        b_age_reg   <= a_age;
        b_idx_reg   <= a_idx_reg;
    end

    // sequencer, scan control, accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            count_reg        <= '0;
            stamp_reg        <= '0;
            snap_reg         <= 1'b0;
            issue_on_reg     <= 1'b0;
            rd_addr_reg      <= '0;
            a_vld_reg        <= 1'b0;
            a_last_reg       <= 1'b0;
            a_idx_reg        <= '0;
            b_vld_reg        <= 1'b0;
            b_last_reg       <= 1'b0;
            min_any_reg      <= 1'b0;
            min_reg          <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            removed_reg      <= '0;
            pick_found_reg   <= 1'b0;
            pick_idx_reg     <= '0;
            pick_dl_reg      <= '0;
            pick_age_reg     <= '0;
            pick_conn_reg    <= '0;
            pick_seq_reg     <= '0;
            pops_reg         <= '0;
            pend_vld_reg     <= 1'b0;
            pend_conn_reg    <= '0;
            pend_seq_reg     <= '0;
            pend_count_reg   <= '0;
            out_vld_reg      <= 1'b0;
            out_kind_reg     <= '0;
            out_conn_reg     <= '0;
            out_seq_reg      <= '0;
            out_removed_reg  <= '0;
            out_used_reg     <= '0;
            out_earliest_reg <= '0;
            out_evalid_reg   <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            // result taken with nothing new behind it
            if (out_vld_reg && rsp.ready && !out_load)
            begin
                out_vld_reg <= 1'b0;
            end

            // read pipeline follows the issue pointer
            a_vld_reg  <= ram_rd_en;
            a_last_reg <= (rd_addr_reg == LAST_IDX);
            a_idx_reg  <= rd_addr_reg;
            b_vld_reg  <= a_vld_reg;
            b_last_reg <= a_vld_reg && a_last_reg;

            // pass start or accumulate
            if (pass_start)
            begin
                rd_addr_reg    <= '0;
                issue_on_reg   <= 1'b1;
                min_any_reg    <= 1'b0;
                free_found_reg <= 1'b0;
                removed_reg    <= '0;
                pick_found_reg <= 1'b0;
            end
            else
            begin
                if (ram_rd_en)
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                    if (rd_addr_reg == LAST_IDX)
                    begin
                        issue_on_reg <= 1'b0;
                    end
                end
                if (b_vld_reg)
                begin
                    if (b_live_reg && (!min_any_reg || (b_entry_reg.deadline < min_reg)))
                    begin
                        min_any_reg <= 1'b1;
                        min_reg     <= b_entry_reg.deadline;
                    end
                    if (b_free_reg && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= b_idx_reg;
                    end
                    if (b_hit_reg)
                    begin
                        removed_reg <= removed_reg + 1'b1;
                    end
                    if (b_elig_reg && b_better)
                    begin
                        pick_found_reg <= 1'b1;
                        pick_idx_reg   <= b_idx_reg;
                        pick_dl_reg    <= b_entry_reg.deadline;
                        pick_age_reg   <= b_age_reg;
                        pick_conn_reg  <= b_entry_reg.conn;
                        pick_seq_reg   <= b_entry_reg.sequence_num;
                    end
                end
            end

            case (state_reg)
                S_CLEAR:
                begin
                    // sweep the entry memory invalid
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (pass_start)
                    begin
                        state_reg    <= S_SCAN;
                        snap_reg     <= (req.action == ctq_pkg::ACT_TICK);
                        pops_reg     <= '0;
                        pend_vld_reg <= 1'b0;
                    end
                end

                S_SCAN:
                begin
                    if (b_vld_reg && b_last_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        case (op_reg)
                            ctq_pkg::ACT_ADD:
                            begin
                                out_vld_reg     <= 1'b1;
                                out_conn_reg    <= conn_reg;
                                out_seq_reg     <= seq_reg;
                                out_removed_reg <= '0;
                                out_last_reg    <= 1'b1;
                                if (free_found_reg)
                                begin
                                    out_kind_reg     <= ctq_pkg::KIND_ADDED;
                                    out_used_reg     <= 5'(count_inc);
                                    out_earliest_reg <= add_earliest;
                                    out_evalid_reg   <= 1'b1;
                                    count_reg        <= count_inc;
                                    stamp_reg        <= stamp_reg + 32'd1;
                                end
                                else
                                begin
                                    out_kind_reg     <= ctq_pkg::KIND_FULL;
                                    out_used_reg     <= 5'(count_reg);
                                    out_earliest_reg <= pass_min;
                                    out_evalid_reg   <= min_any_reg;
                                end
                                state_reg <= S_IDLE;
                            end

                            ctq_pkg::ACT_DELETE:
                            begin
                                out_vld_reg      <= 1'b1;
                                out_kind_reg     <= ctq_pkg::KIND_DELETED;
                                out_conn_reg     <= conn_reg;
                                out_seq_reg      <= '0;
                                out_removed_reg  <= 5'(removed_reg);
                                out_used_reg     <= 5'(count_del);
                                out_earliest_reg <= pass_min;
                                out_evalid_reg   <= min_any_reg;
                                out_last_reg     <= 1'b1;
                                count_reg        <= count_del;
                                state_reg        <= S_IDLE;
                            end

                            ctq_pkg::ACT_TICK:
                            begin
                                // report the previous pop with this pass's minimum
                                if (tick_emit)
                                begin
                                    out_vld_reg      <= 1'b1;
                                    out_removed_reg  <= '0;
                                    out_earliest_reg <= pass_min;
                                    out_evalid_reg   <= min_any_reg;
                                    out_last_reg     <= !tick_pop;
                                    if (pend_vld_reg)
                                    begin
                                        out_kind_reg <= ctq_pkg::KIND_EXPIRED;
                                        out_conn_reg <= pend_conn_reg;
                                        out_seq_reg  <= pend_seq_reg;
                                        out_used_reg <= 5'(pend_count_reg);
                                    end
                                    else
                                    begin
                                        out_kind_reg <= ctq_pkg::KIND_NONE;
                                        out_conn_reg <= '0;
                                        out_seq_reg  <= '0;
                                        out_used_reg <= 5'(count_reg);
                                    end
                                end
                                if (tick_pop)
                                begin
                                    pend_vld_reg   <= 1'b1;
                                    pend_conn_reg  <= pick_conn_reg;
                                    pend_seq_reg   <= pick_seq_reg;
                                    pend_count_reg <= count_pop;
                                    count_reg      <= count_pop;
                                    if (!kick_reg)
                                    begin
                                        stamp_reg <= stamp_reg + 32'd1;
                                    end
                                    pops_reg  <= pops_reg + 1'b1;
                                    snap_reg  <= 1'b0;
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    pend_vld_reg <= 1'b0;
                                    state_reg    <= S_IDLE;
                                end
                            end

                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // memory never sees a write and a read of the same entry in one cycle
    `CTQ_ASSERT_IMP(a_no_rw_collision, clk, rst_n,
                    ram_wr_en && ram_rd_en, ram_wr_addr != rd_addr_reg,
                    "entry memory write and read hit the same entry")

    // the last word of a pass hands over to the decision step
    `CTQ_ASSERT_NXT(a_pass_ends_in_decide, clk, rst_n,
                    b_vld_reg && b_last_reg, state_reg == S_DECIDE,
                    "scan pass did not end in the decision step")

    // a free slot found by a pass implies the count shows room
    `CTQ_ASSERT_IMP(a_free_slot_has_room, clk, rst_n,
                    (state_reg == S_DECIDE) && free_found_reg, count_reg < FULL_CNT,
                    "free slot found while entry count is full")

    // a pending expired result implies at least one pop in this tick
    `CTQ_ASSERT_IMP(a_pending_has_pop, clk, rst_n,
                    pend_vld_reg, pops_reg != '0,
                    "pending expired result without a pop")

endmodule

/* rtl/ctq_ram.sv */
// ============================================================================
// ctq_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ============================================================================
module ctq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* dv/tb_connection_timeout_timer_queue_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_connection_timeout_timer_queue_core
// Self-checking bench for the connection timer table. Requests (add, delete,
// tick and the unused action) go in through the request channel. A behavioral
// table in the bench predicts each result, and every result taken from the
// block is compared field by field in arrival order. Both channels stall in
// random bursts. The run covers directed corner cases, several register
// settings and long stretches of random connection traffic.
// ============================================================================
module tb_connection_timeout_timer_queue_core;

    localparam int TABLE_DEPTH = 16;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4 * (TABLE_DEPTH + 4);
    localparam int DRAIN_LIMIT = 20000;
    localparam int POOL_SIZE = 6;

    // one predicted result
    typedef struct {
        ctq_pkg::kind_t kind;
        logic [15:0]    conn;
        logic [31:0]    seq;
        logic [4:0]     removed;
        logic [4:0]     in_use;
        logic [31:0]    earliest;
        logic           earliest_valid;
        logic           last;
    } timer_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ctq_req_if req_ch();
    ctq_rsp_if rsp_ch();
    ctq_cfg_if cfg_ch();

    connection_timeout_timer_queue_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // bench copy of the timer table and its registers
    logic        tq_valid    [TABLE_DEPTH];
    logic [31:0] tq_deadline [TABLE_DEPTH];
    logic [15:0] tq_conn     [TABLE_DEPTH];
    logic [31:0] tq_seq      [TABLE_DEPTH];
    logic [31:0] tq_order    [TABLE_DEPTH];
    logic [31:0] tq_stamp;
    int          tq_used;
    logic [15:0] cur_wait_time;
    logic        cur_kick;

    timer_result_t pending_results[$];
    int            error_count = 0;
    bit            idle_enable = 1'b1;
    logic [31:0]   traffic_now;
    logic [15:0]   conn_pool [POOL_SIZE];

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    initial
    begin : watchdog
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // timer table prediction
    // ------------------------------------------------------------------------

    function automatic void clear_timer_model();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tq_valid[i]    = 1'b0;
            tq_deadline[i] = '0;
            tq_conn[i]     = '0;
            tq_seq[i]      = '0;
            tq_order[i]    = '0;
        end
        tq_stamp      = '0;
        tq_used       = 0;
        cur_wait_time = ctq_pkg::WAIT_TIME_RESET;
        cur_kick      = 1'b0;
    endfunction

    // now + wait time, saturating at the top of the 32-bit range
    function automatic logic [31:0] deadline_after(logic [31:0] now_s);
        logic [32:0] total;
        total = {1'b0, now_s} + {17'd0, cur_wait_time};
        return total[32] ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    // earlier deadline first, then the older insertion
    function automatic logic pops_first(int a, int b);
        logic [31:0] age_a, age_b;
        if (tq_deadline[a] != tq_deadline[b])
            return tq_deadline[a] < tq_deadline[b];
        age_a = tq_stamp - tq_order[a];
        age_b = tq_stamp - tq_order[b];
        return age_a > age_b;
    endfunction

    function automatic void arm_entry(int slot, logic [15:0] conn, logic [31:0] seq,
                                      logic [31:0] deadline);
        tq_valid[slot]    = 1'b1;
        tq_deadline[slot] = deadline;
        tq_conn[slot]     = conn;
        tq_seq[slot]      = seq;
        tq_order[slot]    = tq_stamp;
        tq_stamp          = tq_stamp + 1;
        tq_used++;
    endfunction

    // result snapshot with the table state as it stands now
    function automatic void push_result(ctq_pkg::kind_t kind, logic [15:0] conn,
                                        logic [31:0] seq, logic [4:0] removed);
        timer_result_t r;
        logic          found;
        logic [31:0]   best;
        found = 1'b0;
        best  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (tq_valid[i] && (!found || tq_deadline[i] < best))
            begin
                best  = tq_deadline[i];
                found = 1'b1;
            end
        end
        r.kind           = kind;
        r.conn           = conn;
        r.seq            = seq;
        r.removed        = removed;
        r.in_use         = tq_used[4:0];
        r.earliest       = found ? best : 32'd0;
        r.earliest_valid = found;
        r.last           = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void predict_request(logic [1:0] act, logic [15:0] conn,
                                            logic [31:0] seq, logic [31:0] now_s);
        int          slot;
        int          pick;
        int          popped;
        logic [4:0]  removed;
        logic        due [TABLE_DEPTH];
        logic [15:0] pop_conn;
        logic [31:0] pop_seq;
        case (act)
            ctq_pkg::ACT_ADD:
            begin
                slot = -1;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (slot < 0 && !tq_valid[i])
                        slot = i;
                end
                if (slot < 0)
                    push_result(ctq_pkg::KIND_FULL, conn, seq, 5'd0);
                else
                begin
                    arm_entry(slot, conn, seq, deadline_after(now_s));
                    push_result(ctq_pkg::KIND_ADDED, conn, seq, 5'd0);
                end
            end
            ctq_pkg::ACT_DELETE:
            begin
                removed = '0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tq_valid[i] && tq_conn[i] == conn)
                    begin
                        tq_valid[i] = 1'b0;
                        tq_used--;
                        removed++;
                    end
                end
                push_result(ctq_pkg::KIND_DELETED, conn, 32'd0, removed);
            end
            ctq_pkg::ACT_TICK:
            begin
                // only entries due when the tick begins are popped
                for (int i = 0; i < TABLE_DEPTH; i++)
                    due[i] = tq_valid[i] && (tq_deadline[i] <= now_s);
                popped = 0;
                while (popped < ctq_pkg::MAX_RESULTS)
                begin
                    pick = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (due[i] && (pick < 0 || pops_first(i, pick)))
                            pick = i;
                    end
                    if (pick < 0)
                        break;
                    due[pick]      = 1'b0;
                    tq_valid[pick] = 1'b0;
                    tq_used--;
                    pop_conn = tq_conn[pick];
                    pop_seq  = tq_seq[pick];
                    if (!cur_kick)
                        arm_entry(pick, pop_conn, pop_seq, deadline_after(now_s));
                    push_result(ctq_pkg::KIND_EXPIRED, pop_conn, pop_seq, 5'd0);
                    popped++;
                end
                if (popped == 0)
                    push_result(ctq_pkg::KIND_NONE, 16'd0, 32'd0, 5'd0);
            end
            default:
                return;
        endcase
        pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d conn %0h seq %0h",
                         $time, rsp_ch.kind, rsp_ch.conn_id_out, rsp_ch.sequence_out);
                error_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
                check_field("conn_id_out", 32'(want.conn), 32'(rsp_ch.conn_id_out));
                check_field("sequence_out", want.seq, rsp_ch.sequence_out);
                check_field("removed_count", 32'(want.removed), 32'(rsp_ch.removed_count));
                check_field("entries_in_use", 32'(want.in_use), 32'(rsp_ch.entries_in_use));
                check_field("earliest_expiry", want.earliest, rsp_ch.earliest_expiry);
                check_field("earliest_valid", 32'(want.earliest_valid),
                            32'(rsp_ch.earliest_valid));
                check_field("last", 32'(want.last), 32'(rsp_ch.last));
            end
        end
    end

    // result back-pressure in random bursts
    initial
    begin : result_stall
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------------

    // one request; valid stays high afterwards so requests can go back to back
    task automatic send_request(logic [1:0] act, logic [15:0] conn, logic [31:0] seq,
                                logic [31:0] now_s);
        int gap;
        @(negedge clk);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.conn_id      <= conn;
        req_ch.sequence_req <= seq;
        req_ch.now          <= now_s;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_request(act, conn, seq, now_s);
    endtask

    // stop requests and wait for every predicted result, then let the block settle
    task automatic drain_results();
        int waited;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && pending_results.size() != 0; waited++)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived, next expected kind %0d",
                     $time, pending_results.size(), pending_results[0].kind);
            error_count++;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [ctq_pkg::CFG_IDX_W-1:0] idx,
                                  logic [ctq_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == ctq_pkg::CFG_WAIT_TIME)
            cur_wait_time = value;
        else if (idx == ctq_pkg::CFG_KICK_ON_TIMEOUT)
            cur_kick = value[0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly ordered traffic on a small set of connections, with some noise
    task automatic send_random_item();
        int          sel;
        logic [1:0]  act;
        logic [15:0] conn;
        logic [31:0] seq;
        logic [31:0] now_s;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            act   = 2'($urandom_range(0, 3));
            conn  = 16'($urandom);
            seq   = $urandom;
            now_s = $urandom;
        end
        else
        begin
            traffic_now = traffic_now + $urandom_range(0, cur_wait_time / 3 + 2);
            conn  = conn_pool[$urandom_range(0, POOL_SIZE - 1)];
            seq   = $urandom;
            now_s = traffic_now;
            if (sel < 50)
                act = ctq_pkg::ACT_ADD;
            else if (sel < 62)
                act = ctq_pkg::ACT_DELETE;
            else
                act = ctq_pkg::ACT_TICK;
        end
        send_request(act, conn, seq, now_s);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings: ties, empty ticks, absent delete, saturation, full table
    task automatic test_directed_cases();
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'd0);
        send_request(ctq_pkg::ACT_ADD, 16'h0000, 32'h0000_0000, 32'd0);
        send_request(ctq_pkg::ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'd19);
        // equal deadlines pop in insertion order and re-arm
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'd20);
        send_request(ctq_pkg::ACT_DELETE, 16'h1234, 32'd0, 32'd20);
        send_request(ctq_pkg::ACT_DELETE, 16'h0000, 32'd0, 32'd20);
        // unused action leaves no trace
        send_request(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // deadline saturates near the top of time
        send_request(ctq_pkg::ACT_ADD, 16'h5A5A, 32'h1234_5678, 32'hFFFF_FFF0);
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_request(ctq_pkg::ACT_ADD, 16'h00A5, 32'h100 + i, 32'd100);
        send_request(ctq_pkg::ACT_ADD, 16'h7777, 32'hCAFE_0001, 32'd100);
        // whole table due in one tick
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(ctq_pkg::ACT_DELETE, 16'h00A5, 32'd0, 32'hFFFF_FFFF);
    endtask

    // zero and largest wait time, kick mode on and off
    task automatic test_register_extremes();
        drain_results();
        write_register(ctq_pkg::CFG_WAIT_TIME, 16'd0);
        write_register(ctq_pkg::CFG_KICK_ON_TIMEOUT, 16'd1);
        send_request(ctq_pkg::ACT_ADD, 16'h0001, 32'h0000_0011, 32'd500);
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'd500);
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'hFFFF_FFFF);
        drain_results();
        write_register(ctq_pkg::CFG_WAIT_TIME, 16'hFFFF);
        write_register(ctq_pkg::CFG_KICK_ON_TIMEOUT, 16'd0);
        send_request(ctq_pkg::ACT_ADD, 16'h0002, 32'h0000_0022, 32'd0);
        send_request(ctq_pkg::ACT_ADD, 16'h0003, 32'h0000_0033, 32'hFFFF_0001);
        send_request(ctq_pkg::ACT_TICK, 16'd0, 32'd0, 32'd65535);
        send_request(ctq_pkg::ACT_DELETE, 16'h0002, 32'd0, 32'd65535);
        send_request(ctq_pkg::ACT_DELETE, 16'h0003, 32'd0, 32'd65535);
    endtask

    // random traffic under several settings, with full pauses of requests between stretches
    task automatic test_random_traffic();
        for (int i = 0; i < POOL_SIZE; i++)
            conn_pool[i] = 16'($urandom);
        traffic_now = 32'd1000;

        drain_results();
        write_register(ctq_pkg::CFG_WAIT_TIME, ctq_pkg::WAIT_TIME_RESET);
        write_register(ctq_pkg::CFG_KICK_ON_TIMEOUT, 16'd0);
        repeat (15) send_random_item();

        drain_results();
        write_register(ctq_pkg::CFG_WAIT_TIME, 16'($urandom_range(1, 200)));
        write_register(ctq_pkg::CFG_KICK_ON_TIMEOUT, 16'd1);
        repeat (8) send_random_item();
        // hold requests until the block has answered everything
        drain_results();
        repeat (8) send_random_item();

        drain_results();
        write_register(ctq_pkg::CFG_WAIT_TIME, 16'd1);
        write_register(ctq_pkg::CFG_KICK_ON_TIMEOUT, 16'd0);
        repeat (10) send_random_item();
    endtask

    // closing stretch with both channels running flat out
    task automatic test_back_to_back();
        drain_results();
        write_register(ctq_pkg::CFG_WAIT_TIME, 16'd5);
        idle_enable = 1'b0;
        repeat (20) send_random_item();
    endtask

    initial
    begin : stimulus
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ctq_pkg::ACT_ADD;
        req_ch.conn_id      = '0;
        req_ch.sequence_req = '0;
        req_ch.now          = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = ctq_pkg::CFG_WAIT_TIME;
        cfg_ch.data         = '0;
        clear_timer_model();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_back_to_back();
        drain_results();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
